// ----- rtl/lf_time_signal_envelope_gen_assert.svh -----
// Assertion macros for the envelope generator. Synthesis builds define SYNTH.
`ifndef LF_TIME_SIGNAL_ENVELOPE_GEN_ASSERT_SVH
`define LF_TIME_SIGNAL_ENVELOPE_GEN_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define LFE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lf envelope: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define LFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lf envelope: next-cycle check failed");
`else
`define LFE_ASSERT_IMP(lbl, ante, cons)
`define LFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/lfe_pkg.sv -----
`timescale 1ns / 1ps
package lfe_pkg;

    localparam int SEGMENTS_DEF     = 8;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int PHASE_WIDTH_DEF  = 32;

    localparam int RATE_W     = 20;
    localparam int STEP_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W = 48;
    localparam int IN_TUSER_W = 2;
    localparam int ELAPSED_W  = 31;
    localparam int TARGET_W   = 30;
    localparam int LEN_W      = 30;
    localparam int DUR_W      = 10;
    localparam int ENTRY_W    = 12;
    localparam int SEC_W      = 6;
    localparam int SINE_W     = 15;
    localparam int OUT_META_W = 10;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX        = '1;
    localparam logic [DUR_W-1:0]     MS_PER_SECOND      = 10'd1000;
    localparam logic [SEC_W-1:0]     SECONDS_PER_MINUTE = 6'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP     = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_START  = 2'd1,
        CMD_LOAD   = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        LVL_HIGH = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_OFF  = 2'd2
    } level_t;

    typedef struct packed {
        logic [3:0]        seg_count;
        logic [1:0]        seg_power;
        logic [DUR_W-1:0]  seg_duration_ms;
        logic [2:0]        seg_slot;
        logic [RATE_W-1:0] start_offset;
        logic [SEC_W-1:0]  start_second;
    } in_word_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_LOAD,
        OP_FINISH,
        OP_LOC_INIT,
        OP_LOC_MUL,
        OP_LOC_CMP,
        OP_LOC_LEVEL,
        OP_TICK_A,
        OP_TICK_B,
        OP_TICK_C
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic loc_empty;
        logic loc_match;
        logic loc_last;
        logic boundary;
        logic out_free;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOC_INIT,
        ST_LOC_MUL,
        ST_LOC_CMP,
        ST_LOC_LEVEL,
        ST_TICK_A,
        ST_TICK_B,
        ST_TICK_C,
        ST_TICK_OUT
    } ctl_state_t;

    // Quarter-wave sine in Q15, seventeen points from 0 to a quarter turn.
    localparam logic [SINE_W-1:0] QUARTER_SINE [17] = '{
        15'd0,     15'd3212,  15'd6393,  15'd9512,  15'd12539, 15'd15446,
        15'd18204, 15'd20787, 15'd23170, 15'd25329, 15'd27245, 15'd28898,
        15'd30273, 15'd31356, 15'd32137, 15'd32609, 15'd32767
    };

    function automatic level_t power_code(input logic [1:0] p);
        level_t lvl;
        case (p)
            LVL_LOW: lvl = LVL_LOW;
            LVL_OFF: lvl = LVL_OFF;
            default: lvl = LVL_HIGH;
        endcase
        return lvl;
    endfunction

endpackage

// ----- rtl/lfe_ctrl.sv -----
`timescale 1ns / 1ps
module lfe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  lfe_pkg::cmd_t       in_cmd,
    output logic                in_ready,
    input  lfe_pkg::dp_status_t status,
    output lfe_pkg::dp_cmd_t    cmd
);
    import lfe_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_cmd)
                        CMD_TICK:
                        begin
                            state_next = ST_TICK_A;
                        end
                        CMD_START:
                        begin
                            cmd.op     = OP_START;
                            state_next = ST_LOC_INIT;
                        end
                        CMD_LOAD:
                        begin
                            cmd.op = OP_LOAD;
                        end
                        CMD_FINISH:
                        begin
                            cmd.op     = OP_FINISH;
                            state_next = ST_LOC_INIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOC_INIT:
            begin
                cmd.op     = OP_LOC_INIT;
                state_next = status.loc_empty ? ST_LOC_LEVEL : ST_LOC_MUL;
            end
            ST_LOC_MUL:
            begin
                cmd.op     = OP_LOC_MUL;
                state_next = ST_LOC_CMP;
            end
            ST_LOC_CMP:
            begin
                cmd.op = OP_LOC_CMP;
                if (status.loc_match || status.loc_last)
                begin
                    state_next = ST_LOC_LEVEL;
                end
                else
                begin
                    state_next = ST_LOC_MUL;
                end
            end
            ST_LOC_LEVEL:
            begin
                cmd.op     = OP_LOC_LEVEL;
                state_next = ST_IDLE;
            end
            ST_TICK_A:
            begin
                cmd.op     = OP_TICK_A;
                state_next = ST_TICK_B;
            end
            ST_TICK_B:
            begin
                cmd.op     = OP_TICK_B;
                state_next = ST_TICK_C;
            end
            ST_TICK_C:
            begin
                cmd.op     = OP_TICK_C;
                state_next = ST_TICK_OUT;
            end
            ST_TICK_OUT:
            begin
                // Hold here while the previous word still sits unread.
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.boundary ? ST_LOC_INIT : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lfe_datapath.sv -----
`timescale 1ns / 1ps
module lfe_datapath #(
    parameter int SEGMENTS     = lfe_pkg::SEGMENTS_DEF,
    parameter int SAMPLE_WIDTH = lfe_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_WIDTH  = lfe_pkg::PHASE_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  lfe_pkg::dp_cmd_t                             cmd,
    output lfe_pkg::dp_status_t                          status,
    input  lfe_pkg::in_word_t                            in_word,
    input  logic                                         cfg_we,
    input  logic [lfe_pkg::CFG_IDX_W-1:0]                cfg_idx,
    input  logic [lfe_pkg::CFG_DATA_W-1:0]               cfg_wdata,
    input  logic                                         out_ready,
    output logic                                         out_valid,
    output logic [SAMPLE_WIDTH+lfe_pkg::OUT_META_W-1:0]  out_data
);
    import lfe_pkg::*;

    localparam int IDX_W   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int POS_W   = $clog2(SEGMENTS + 1);
    localparam int CONS_W  = POS_W + DUR_W;
    localparam int PROD_W  = CONS_W + RATE_W;
    localparam int AMP_W   = SAMPLE_WIDTH - 1;
    localparam int PROD2_W = AMP_W + SINE_W;
    localparam int OUT_W   = SAMPLE_WIDTH + OUT_META_W;
    localparam int INTERP_W = 30;
    localparam longint AMP_SCALE = longint'(1) << AMP_W;
    localparam logic [AMP_W-1:0] AMP_HIGH = AMP_W'((9 * AMP_SCALE + 5) / 10);
    localparam logic [AMP_W-1:0] AMP_LOW  = AMP_W'((135 * AMP_SCALE + 500) / 1000);

    // Architectural state.
    logic [ENTRY_W-1:0]     seg_table_reg [SEGMENTS];
    logic [POS_W-1:0]       total_reg, total_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [RATE_W-1:0]      sec_elapsed_reg, sec_elapsed_next;
    logic [SEC_W-1:0]       sec_index_reg, sec_index_next;
    logic [RATE_W-1:0]      pending_reg, pending_next;
    level_t                 level_reg, level_next;
    logic [PHASE_WIDTH-1:0] phase_reg, phase_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic                   carrier_reg, carrier_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;

    // Segment walk working registers.
    logic [TARGET_W-1:0]    target_reg, target_next;
    logic [POS_W-1:0]       loc_i_reg, loc_i_next;
    logic [CONS_W-1:0]      consumed_reg, consumed_next;
    logic [CONS_W-1:0]      sum_reg, sum_next;
    logic [PROD_W-1:0]      csr_reg, csr_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [DUR_W-1:0]       dur_reg, dur_next;

    // Tick working registers.
    level_t                 code_reg, code_next;
    logic [SINE_W-1:0]      base_reg, base_next;
    logic [INTERP_W-1:0]    interp_reg, interp_next;
    logic                   sat_reg, sat_next;
    logic                   neg_reg, neg_next;
    logic [ELAPSED_W-1:0]   inc_reg, inc_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   adv_ok_reg, adv_ok_next;
    logic [RATE_W:0]        sec_step_reg, sec_step_next;
    logic [SINE_W-1:0]      mag_reg, mag_next;
    logic                   adv_taken_reg, adv_taken_next;
    logic                   boundary_reg, boundary_next;
    logic                   roll_reg, roll_next;
    logic [PROD2_W-1:0]     prod2_reg, prod2_next;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    // Shared combinational terms.
    logic [POS_W-1:0]          rd_addr;
    logic [ENTRY_W-1:0]        rd_entry;
    logic [PHASE_WIDTH+31:0]   phase_ext;
    logic [31:0]               phase_top;
    logic [21:0]               r_fold;
    logic [22:0]               r_quarter;
    logic [4:0]                sine_idx;
    logic [17:0]               sine_frac;
    logic [4:0]                sine_idx_up;
    logic [11:0]               sine_diff;
    logic [31:0]               inc_full;
    logic [CONS_W-1:0]         sum_full;
    logic [PROD_W-1:0]         e_full;
    logic                      loc_match;
    logic [POS_W:0]            loc_i_inc;
    logic [INTERP_W:0]         interp_rnd;
    logic [AMP_W-1:0]          amp_sel;
    logic [PROD2_W:0]          prod2_rnd;
    logic [AMP_W-1:0]          carr_mag;
    logic [SAMPLE_WIDTH-1:0]   carr_word;
    logic [SAMPLE_WIDTH-1:0]   sample_word;
    logic [SEC_W-1:0]          sec_inc;

    // One table read port: the walk index during the multiply step, else the position.
    always_comb
    begin
        rd_addr  = (cmd.op == OP_LOC_MUL) ? loc_i_reg : pos_reg;
        rd_entry = '0;
        if (rd_addr < POS_W'(SEGMENTS))
        begin
            rd_entry = seg_table_reg[rd_addr[IDX_W-1:0]];
        end
    end

    // Carrier: quadrant fold and table lookup for linear interpolation.
    always_comb
    begin
        phase_ext   = {phase_reg, 32'd0} >> PHASE_WIDTH;
        phase_top   = phase_ext[31:0];
        r_fold      = phase_top[29:8];
        r_quarter   = phase_top[30] ? (23'h400000 - {1'b0, r_fold}) : {1'b0, r_fold};
        sine_idx    = r_quarter[22:18];
        sine_frac   = r_quarter[17:0];
        sine_idx_up = {1'b0, sine_idx[3:0]} + 5'd1;
        sine_diff   = 12'(QUARTER_SINE[sine_idx_up] - QUARTER_SINE[sine_idx[3:0]]);
    end

    always_comb
    begin
        case (code_reg)
            LVL_HIGH: amp_sel = AMP_HIGH;
            LVL_LOW:  amp_sel = AMP_LOW;
            default:  amp_sel = '0;
        endcase
    end

    always_comb
    begin
        inc_full   = {1'b0, elapsed_reg} + 32'd1000;
        sum_full   = consumed_reg + CONS_W'(rd_entry[DUR_W-1:0]);
        e_full     = PROD_W'(target_reg) - csr_reg;
        loc_match  = (dur_reg == '0) || (PROD_W'(target_reg) < prod_reg);
        loc_i_inc  = {1'b0, loc_i_reg} + 1'b1;
        interp_rnd = {1'b0, interp_reg} + (INTERP_W + 1)'(18'h20000);
        prod2_rnd  = {1'b0, prod2_reg} + (PROD2_W + 1)'(16384);
        carr_mag   = AMP_W'(prod2_rnd >> 15);
        carr_word  = neg_reg ? (SAMPLE_WIDTH'(0) - {1'b0, carr_mag}) : {1'b0, carr_mag};
        sample_word = carrier_reg ? carr_word : {1'b0, amp_sel};
        sec_inc    = sec_index_reg + 1'b1;
    end

    assign status.loc_empty = (total_reg == '0);
    assign status.loc_match = loc_match;
    assign status.loc_last  = (loc_i_inc >= {1'b0, total_reg});
    assign status.boundary  = boundary_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        total_next       = total_reg;
        pos_next         = pos_reg;
        elapsed_next     = elapsed_reg;
        sec_elapsed_next = sec_elapsed_reg;
        sec_index_next   = sec_index_reg;
        pending_next     = pending_reg;
        level_next       = level_reg;
        phase_next       = phase_reg;
        target_next      = target_reg;
        loc_i_next       = loc_i_reg;
        consumed_next    = consumed_reg;
        sum_next         = sum_reg;
        csr_next         = csr_reg;
        prod_next        = prod_reg;
        dur_next         = dur_reg;
        code_next        = code_reg;
        base_next        = base_reg;
        interp_next      = interp_reg;
        sat_next         = sat_reg;
        neg_next         = neg_reg;
        inc_next         = inc_reg;
        len_next         = len_reg;
        adv_ok_next      = adv_ok_reg;
        sec_step_next    = sec_step_reg;
        mag_next         = mag_reg;
        adv_taken_next   = adv_taken_reg;
        boundary_next    = boundary_reg;
        roll_next        = roll_reg;
        prod2_next       = prod2_reg;
        case (cmd.op)
            OP_START:
            begin
                sec_index_next   = (in_word.start_second >= SECONDS_PER_MINUTE) ?
                                   (in_word.start_second - SECONDS_PER_MINUTE) :
                                   in_word.start_second;
                sec_elapsed_next = in_word.start_offset;
                pending_next     = in_word.start_offset;
            end
            OP_FINISH:
            begin
                if (int'(in_word.seg_count) > SEGMENTS)
                begin
                    total_next = POS_W'(SEGMENTS);
                end
                else
                begin
                    total_next = POS_W'(in_word.seg_count);
                end
            end
            OP_LOC_INIT:
            begin
                target_next   = pending_reg * MS_PER_SECOND;
                loc_i_next    = '0;
                consumed_next = '0;
                csr_next      = '0;
                pos_next      = '0;
                elapsed_next  = '0;
            end
            OP_LOC_MUL:
            begin
                dur_next  = rd_entry[DUR_W-1:0];
                sum_next  = sum_full;
                prod_next = sum_full * rate_reg;
            end
            OP_LOC_CMP:
            begin
                if (loc_match)
                begin
                    pos_next     = loc_i_reg;
                    elapsed_next = (e_full > PROD_W'(ELAPSED_MAX)) ? ELAPSED_MAX :
                                   ELAPSED_W'(e_full);
                end
                else
                begin
                    consumed_next = sum_reg;
                    csr_next      = prod_reg;
                    loc_i_next    = POS_W'(loc_i_inc);
                end
            end
            OP_LOC_LEVEL:
            begin
                level_next = (pos_reg < total_reg) ? power_code(rd_entry[11:10]) : LVL_HIGH;
            end
            OP_TICK_A:
            begin
                code_next     = level_reg;
                base_next     = QUARTER_SINE[sine_idx[3:0]];
                interp_next   = sine_diff * sine_frac;
                sat_next      = sine_idx[4];
                neg_next      = phase_top[31];
                if (carrier_reg)
                begin
                    phase_next = phase_reg + PHASE_WIDTH'(step_reg);
                end
                inc_next      = (inc_full > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX :
                                ELAPSED_W'(inc_full);
                len_next      = rd_entry[DUR_W-1:0] * rate_reg;
                adv_ok_next   = (pos_reg < total_reg) && (rd_entry[DUR_W-1:0] != '0);
                sec_step_next = {1'b0, sec_elapsed_reg} + 1'b1;
            end
            OP_TICK_B:
            begin
                mag_next = sat_reg ? QUARTER_SINE[16] :
                           (base_reg + SINE_W'(interp_rnd >> 18));
                adv_taken_next = adv_ok_reg && (inc_reg >= {1'b0, len_reg});
                if (adv_ok_reg && (inc_reg >= {1'b0, len_reg}))
                begin
                    elapsed_next = inc_reg - {1'b0, len_reg};
                    pos_next     = pos_reg + 1'b1;
                end
                else
                begin
                    elapsed_next = inc_reg;
                end
                boundary_next = (sec_step_reg >= {1'b0, rate_reg});
                roll_next     = 1'b0;
                if (sec_step_reg >= {1'b0, rate_reg})
                begin
                    sec_elapsed_next = RATE_W'(sec_step_reg - {1'b0, rate_reg});
                    pending_next     = '0;
                    if (sec_inc >= SECONDS_PER_MINUTE)
                    begin
                        sec_index_next = '0;
                        roll_next      = 1'b1;
                    end
                    else
                    begin
                        sec_index_next = sec_inc;
                    end
                end
                else
                begin
                    sec_elapsed_next = RATE_W'(sec_step_reg);
                end
            end
            OP_TICK_C:
            begin
                if (adv_taken_reg)
                begin
                    level_next = (pos_reg < total_reg) ? power_code(rd_entry[11:10]) :
                                 LVL_HIGH;
                end
                prod2_next = amp_sel * mag_reg;
            end
            default:
            begin
                total_next = total_reg;
            end
        endcase
    end

    always_comb
    begin
        rate_next    = rate_reg;
        carrier_next = carrier_reg;
        step_next    = step_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_SAMPLE_RATE:    rate_next    = cfg_wdata[RATE_W-1:0];
                CFG_CARRIER_ENABLE: carrier_next = cfg_wdata[0];
                CFG_PHASE_STEP:     step_next    = cfg_wdata[STEP_W-1:0];
                default:            rate_next    = rate_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {roll_reg, boundary_reg, sec_index_reg, code_reg, sample_word};
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg       <= '0;
            pos_reg         <= '0;
            elapsed_reg     <= '0;
            sec_elapsed_reg <= '0;
            sec_index_reg   <= '0;
            pending_reg     <= '0;
            level_reg       <= LVL_HIGH;
            phase_reg       <= '0;
            rate_reg        <= RATE_W'(48000);
            carrier_reg     <= 1'b0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            total_reg       <= total_next;
            pos_reg         <= pos_next;
            elapsed_reg     <= elapsed_next;
            sec_elapsed_reg <= sec_elapsed_next;
            sec_index_reg   <= sec_index_next;
            pending_reg     <= pending_next;
            level_reg       <= level_next;
            phase_reg       <= phase_next;
            rate_reg        <= rate_next;
            carrier_reg     <= carrier_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg    <= target_next;
        loc_i_reg     <= loc_i_next;
        consumed_reg  <= consumed_next;
        sum_reg       <= sum_next;
        csr_reg       <= csr_next;
        prod_reg      <= prod_next;
        dur_reg       <= dur_next;
        code_reg      <= code_next;
        base_reg      <= base_next;
        interp_reg    <= interp_next;
        sat_reg       <= sat_next;
        neg_reg       <= neg_next;
        inc_reg       <= inc_next;
        len_reg       <= len_next;
        adv_ok_reg    <= adv_ok_next;
        sec_step_reg  <= sec_step_next;
        mag_reg       <= mag_next;
        adv_taken_reg <= adv_taken_next;
        boundary_reg  <= boundary_next;
        roll_reg      <= roll_next;
        prod2_reg     <= prod2_next;
        out_data_reg  <= out_data_next;
    end

    // The segment table holds whatever software loads; slots past the depth are dropped.
    always_ff @(posedge clk)
    begin
        if ((cmd.op == OP_LOAD) && (int'(in_word.seg_slot) < SEGMENTS))
        begin
            seg_table_reg[IDX_W'(in_word.seg_slot)] <= {in_word.seg_power,
                                                        in_word.seg_duration_ms};
        end
    end

endmodule

// ----- rtl/lf_time_signal_envelope_gen.sv -----
// Tick: the word runs through TICK_A, TICK_B and TICK_C; its result is registered in
// TICK_OUT once the output register is free, and no word is taken before that. Start,
// finish and a tick that opens a new second walk the table: LOC_INIT, a multiply and a
// compare step per entry up to the match (at most SEGMENTS), LOC_LEVEL. Reset (rst_n low,
// asynchronous) resets timing, level and configuration; the table is undefined until loaded.
`timescale 1ns / 1ps
`include "lf_time_signal_envelope_gen_assert.svh"
module lf_time_signal_envelope_gen #(
    parameter int SEGMENTS     = lfe_pkg::SEGMENTS_DEF,
    parameter int SAMPLE_WIDTH = lfe_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_WIDTH  = lfe_pkg::PHASE_WIDTH_DEF,
    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + lfe_pkg::OUT_META_W + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input word.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, lowest bit up: start_second[5:0], start_offset[19:0], seg_slot[2:0],
    // seg_duration_ms[9:0], seg_power[1:0], seg_count[3:0], zero fill.
    input  logic [lfe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser, lowest bit up: cmd[1:0].
    input  logic [lfe_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    // Result word.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata, lowest bit up: sample[SAMPLE_WIDTH-1:0] (signed), envelope_code[1:0],
    // second_now[5:0], need_table, minute_rollover, zero fill.
    output logic [OUT_TDATA_W-1:0]             m_axis_tdata,
    // Configuration write.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lfe_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lfe_pkg::*;

    localparam int OUT_W = SAMPLE_WIDTH + OUT_META_W;

    dp_cmd_t          ctl_cmd;
    dp_status_t       dp_status;
    in_word_t         in_word;
    logic [OUT_W-1:0] out_fields;

    // The input fields are packed from bit 0 upward; the packed struct lists them
    // highest first, so a plain slice of tdata lines them up.
    assign in_word = s_axis_tdata[$bits(in_word_t)-1:0];

    // Registers are written whenever offered. Software must only write them while the block is
    // idle; the block does not enforce this and has no interlock with the sequencer.
    assign cfg_ready = 1'b1;

    // The controller owns the input handshake and sequences the datapath. A tick walks
    // through three working states (sine fold and lookup, interpolation and timing update,
    // envelope product) before its word is loaded into the output register. The output
    // register is the skid stage: a new word is accepted while a result waits, and only
    // the load of the following result waits for the downstream side.
    lfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (cmd_t'(s_axis_tuser)),
        .in_ready (s_axis_tready),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    // The datapath keeps the segment table, the milli-sample segment timer, the second
    // and minute counters, the carrier phase accumulator and the configuration registers.
    // At a second boundary, and after start or finish, the table is walked, a multiply and a
    // compare step per entry, to find the segment that covers the pending offset.
    lfe_datapath #(
        .SEGMENTS     (SEGMENTS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PHASE_WIDTH  (PHASE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .status    (dp_status),
        .in_word   (in_word),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_fields)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_fields);

    // A tick keeps the block busy for its working cycles.
    `LFE_ASSERT_NEXT(a_tick_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TICK), !s_axis_tready)
    // A table load completes in the cycle it is accepted.
    `LFE_ASSERT_NEXT(a_load_one_cycle, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD), s_axis_tready)
    // A result is never loaded over a word the downstream side has not taken.
    `LFE_ASSERT_IMP(a_no_overwrite, ctl_cmd.out_load, !m_axis_tvalid || m_axis_tready)

endmodule

// ----- test/tb_lf_time_signal_envelope_gen.sv -----
`timescale 1ns / 1ps
module tb_lf_time_signal_envelope_gen;
    import lfe_pkg::*;

    // Result word layout: sample, envelope code, second, need_table, minute_rollover, fill.
    localparam int SW    = SAMPLE_WIDTH_DEF;
    localparam int OUT_W = ((SW + OUT_META_W + 7) / 8) * 8;

    // Envelope amplitudes in Q1.15: 0.9 of full scale, and 15 percent of that.
    localparam int AMP_HIGH = (9 * (1 << (SW - 1)) + 5) / 10;
    localparam int AMP_LOW  = (135 * (1 << (SW - 1)) + 500) / 1000;

    localparam int unsigned MAX_OFFSET = 999_999;
    // The pause after the last word outlasts the longest table walk, so the block is idle after it.
    localparam int IDLE_PAUSE = 40;
    // No single word should keep both channels quiet beyond its working states and table walk,
    // even with 61 percent idling on one side, so this is many times the worst honest gap.
    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        cmd_t     cmd;
        in_word_t fields;
    } stim_word_t;

    typedef struct {
        logic [SW-1:0]    sample;
        level_t           code;
        logic [SEC_W-1:0] second;
        logic             need;
        logic             roll;
    } tick_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_SAMPLE_RATE;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    lf_time_signal_envelope_gen dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Words waiting to be driven, the word currently on the bus, and tick results still owed.
    stim_word_t   cmd_queue [$];
    stim_word_t   word_on_bus;
    tick_result_t due_samples [$];
    tick_result_t oldest_due;
    int unsigned  words_queued   = 0;
    int unsigned  words_owed     = 0;
    int unsigned  mismatches     = 0;
    int unsigned  quiet_cycles   = 0;
    int unsigned  src_idle_pct   = 0;
    int unsigned  sink_stall_pct = 0;

    // Our own copy of the generator state, starting from the reset values.
    logic [ENTRY_W-1:0] seg_table [SEGMENTS_DEF];
    int unsigned        seg_total   = 0;
    int unsigned        seg_pos     = 0;
    longint unsigned    seg_elapsed = 0;
    int unsigned        sec_elapsed = 0;
    int unsigned        sec_index   = 0;
    int unsigned        pend_offset = 0;
    level_t             level_now   = LVL_HIGH;
    logic [31:0]        car_phase   = '0;
    int unsigned        rate_reg    = 48000;
    logic               carrier_on  = 1'b0;
    logic [31:0]        step_reg    = '0;

    // Quarter-wave sine in Q15, seventeen points from zero to a quarter turn.
    int unsigned sine_quarter [17] = '{
        0, 3212, 6393, 9512, 12539, 15446, 18204, 20787, 23170,
        25329, 27245, 28898, 30273, 31356, 32137, 32609, 32767
    };

    // The level follows the power of the current segment; running past the valid count
    // falls back to the high level, as does the unused power code.
    task automatic refresh_level();
        logic [1:0] pwr;
        if (seg_pos < seg_total)
        begin
            pwr = seg_table[seg_pos][ENTRY_W-1:DUR_W];
            level_now = (pwr == LVL_LOW) ? LVL_LOW : (pwr == LVL_OFF) ? LVL_OFF : LVL_HIGH;
        end
        else
        begin
            level_now = LVL_HIGH;
        end
    endtask

    // Walks the table in milli-samples to find the segment holding the given offset.
    // A fill segment (zero duration) takes everything that remains; if nothing matches,
    // segment 0 is used from its start.
    task automatic seek_segment(int unsigned offset);
        longint unsigned target, consumed, dur, into;
        target   = longint'(offset) * 1000;
        consumed = 0;
        seg_pos  = 0;
        seg_elapsed = 0;
        for (int i = 0; i < seg_total; i++)
        begin
            dur = seg_table[i][DUR_W-1:0];
            if (dur == 0 || target < (consumed + dur) * rate_reg)
            begin
                into = target - consumed * rate_reg;
                seg_pos = i;
                seg_elapsed = (into > ELAPSED_MAX) ? longint'(ELAPSED_MAX) : into;
                break;
            end
            consumed += dur;
        end
        refresh_level();
    endtask

    // Applies one accepted word to the state copy; a tick also queues the result it owes.
    task automatic predict_envelope(stim_word_t w);
        tick_result_t    res;
        int unsigned     nxt, r, idx, frac, v;
        longint unsigned seg_len, d;
        int              amp, smp, mag;
        case (w.cmd)
            CMD_START:
            begin
                sec_index = (w.fields.start_second >= SECONDS_PER_MINUTE) ?
                            w.fields.start_second - SECONDS_PER_MINUTE : w.fields.start_second;
                sec_elapsed = w.fields.start_offset;
                pend_offset = sec_elapsed;
                seek_segment(pend_offset);
            end
            CMD_LOAD:
            begin
                seg_table[w.fields.seg_slot] = {w.fields.seg_power, w.fields.seg_duration_ms};
            end
            CMD_FINISH:
            begin
                seg_total = (w.fields.seg_count > SEGMENTS_DEF) ? SEGMENTS_DEF
                                                                : w.fields.seg_count;
                seek_segment(pend_offset);
            end
            default:
            begin
                // The sample uses the level in force before this tick moves anything on.
                res.code = level_now;
                amp = (level_now == LVL_HIGH) ? AMP_HIGH : (level_now == LVL_LOW) ? AMP_LOW : 0;
                smp = amp;
                if (carrier_on)
                begin
                    // Quadrant from the top two phase bits; the odd quadrants run the
                    // table backwards and the upper half turn is negative.
                    r = car_phase[29:8];
                    if (car_phase[30])
                        r = 32'h40_0000 - r;
                    idx  = r >> 18;
                    frac = r & 32'h3_FFFF;
                    if (idx >= 16)
                    begin
                        v = sine_quarter[16];
                    end
                    else
                    begin
                        d = sine_quarter[idx + 1] - sine_quarter[idx];
                        v = sine_quarter[idx] + int'((d * frac + 64'h2_0000) >> 18);
                    end
                    mag = int'((longint'(amp) * v + 16384) >> 15);
                    smp = car_phase[31] ? -mag : mag;
                    car_phase += step_reg;
                end

                seg_elapsed += 1000;
                if (seg_elapsed > ELAPSED_MAX)
                    seg_elapsed = ELAPSED_MAX;
                if (seg_pos < seg_total)
                begin
                    // Any non-zero duration can end, even when its length in
                    // milli-samples is zero.
                    seg_len = longint'(seg_table[seg_pos][DUR_W-1:0]) * rate_reg;
                    if (seg_table[seg_pos][DUR_W-1:0] != '0 && seg_elapsed >= seg_len)
                    begin
                        seg_elapsed -= seg_len;
                        seg_pos++;
                        refresh_level();
                    end
                end

                // An offset beyond one second drops a whole second per tick until it fits.
                res.need = 1'b0;
                res.roll = 1'b0;
                nxt = sec_elapsed + 1;
                if (nxt >= rate_reg)
                begin
                    nxt -= rate_reg;
                    sec_index++;
                    if (sec_index >= SECONDS_PER_MINUTE)
                    begin
                        sec_index = 0;
                        res.roll = 1'b1;
                    end
                    pend_offset = 0;
                    seek_segment(0);
                    res.need = 1'b1;
                end
                sec_elapsed = nxt & 32'hF_FFFF;

                res.sample = SW'(smp);
                res.second = SEC_W'(sec_index);
                due_samples.push_back(res);
            end
        endcase
    endtask

    // Driver: holds a word until it is taken, then either offers the next one or idles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_envelope(word_on_bus);
                words_owed--;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    word_on_bus = cmd_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'(word_on_bus.fields);
                    s_axis_tuser  <= word_on_bus.cmd;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic check_field(string what, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Monitor: every result word is matched against the oldest tick still owed.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_samples.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                oldest_due = due_samples.pop_front();
                check_field("sample", oldest_due.sample, m_axis_tdata[SW-1:0]);
                check_field("envelope_code", oldest_due.code, m_axis_tdata[SW+1:SW]);
                check_field("second_now", oldest_due.second, m_axis_tdata[SW+7:SW+2]);
                check_field("need_table", oldest_due.need, m_axis_tdata[SW+8]);
                check_field("minute_rollover", oldest_due.roll, m_axis_tdata[SW+9]);
                check_field("zero fill", 0, m_axis_tdata[OUT_W-1:SW+10]);
            end
        end
    end

    // Watchdog: counts cycles in which no channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("lf_time_signal_envelope_gen test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Unused fields of every word carry random bits so that the block is seen to ignore them.
    function automatic in_word_t scrambled();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(in_word_t)-1:0];
    endfunction

    task automatic send_word(cmd_t c, in_word_t f);
        cmd_queue.push_back('{cmd: c, fields: f});
        words_queued++;
        words_owed++;
    endtask

    task automatic send_tick();
        send_word(CMD_TICK, scrambled());
    endtask

    task automatic send_start(int unsigned sec, int unsigned off);
        in_word_t f;
        f = scrambled();
        f.start_second = SEC_W'(sec);
        f.start_offset = RATE_W'(off);
        send_word(CMD_START, f);
    endtask

    task automatic send_load(int unsigned slot, int unsigned dur, int unsigned pwr);
        in_word_t f;
        f = scrambled();
        f.seg_slot        = 3'(slot);
        f.seg_duration_ms = DUR_W'(dur);
        f.seg_power       = 2'(pwr);
        send_word(CMD_LOAD, f);
    endtask

    task automatic send_finish(int unsigned cnt);
        in_word_t f;
        f = scrambled();
        f.seg_count = 4'(cnt);
        send_word(CMD_FINISH, f);
    endtask

    // Holds a register write up until it is taken; the caller lowers valid afterwards.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Called at a rising edge while the block is idle.
    task automatic program_regs(int unsigned rate, logic enable, logic [31:0] step);
        write_reg(CFG_SAMPLE_RATE, rate);
        write_reg(CFG_CARRIER_ENABLE, CFG_DATA_W'(enable));
        write_reg(CFG_PHASE_STEP, step);
        cfg_valid <= 1'b0;
        rate_reg   = rate;
        carrier_on = enable;
        step_reg   = step;
    endtask

    // Waits until every word is taken and every tick answered, then lets any walk
    // started by a start or finish word run out.
    task automatic settle();
        while (words_owed != 0 || due_samples.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE)
            @(posedge clk);
    endtask

    // Mostly well-formed seconds: load a table, finish it, start somewhere interesting in it
    // and tick on. The start point is chosen near a segment end or the end of the second so
    // that transitions and boundaries come within a few ticks at any sample rate. A little
    // noise (stray starts, finishes and loads) is mixed into the ticks.
    task automatic random_phase(int unsigned words);
        int unsigned     first, k, cnt, ms_sum, off, sec, n_ticks, dur;
        longint unsigned seg_end;
        int unsigned     ends [SEGMENTS_DEF];
        first = words_queued;
        while (words_queued - first < words)
        begin
            k = $urandom_range(1, SEGMENTS_DEF);
            ms_sum = 0;
            for (int i = 0; i < k; i++)
            begin
                case ($urandom_range(9))
                    0:       dur = 0;
                    1:       dur = MS_PER_SECOND;
                    2, 3:    dur = $urandom_range(1, MS_PER_SECOND);
                    default: dur = $urandom_range(1, 6);
                endcase
                send_load(i, dur, $urandom_range(0, 3));
                ms_sum += dur;
                ends[i] = ms_sum;
            end
            if ($urandom_range(3) == 0)
                send_load($urandom_range(0, SEGMENTS_DEF - 1), $urandom_range(0, MS_PER_SECOND),
                          $urandom_range(0, 3));
            cnt = ($urandom_range(7) == 0) ? $urandom_range(0, 15) : k;
            send_finish(cnt);

            case ($urandom_range(3))
                0: off = $urandom_range(0, 20);
                1: off = rate_reg - $urandom_range(1, 25);
                2:
                begin
                    seg_end = longint'(ends[$urandom_range(0, k - 1)]) * rate_reg / 1000;
                    if (seg_end > MAX_OFFSET)
                        off = $urandom_range(0, MAX_OFFSET);
                    else if (seg_end > 20)
                        off = seg_end - $urandom_range(1, 20);
                    else
                        off = seg_end;
                end
                default: off = $urandom_range(0, MAX_OFFSET);
            endcase
            // Second 59 is favoured so that minute rollover comes up often.
            sec = ($urandom_range(3) == 0) ? 59 : $urandom_range(0, 63);
            send_start(sec, off);

            n_ticks = $urandom_range(8, 30);
            for (int t = 0; t < n_ticks; t++)
            begin
                send_tick();
                if ($urandom_range(24) == 0)
                begin
                    case ($urandom_range(2))
                        0: send_start($urandom_range(0, 63), $urandom_range(0, MAX_OFFSET));
                        1: send_finish($urandom_range(0, 15));
                        default: send_load($urandom_range(0, SEGMENTS_DEF - 1),
                                           $urandom_range(0, MS_PER_SECOND),
                                           $urandom_range(0, 3));
                    endcase
                end
            end
        end
    endtask

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset configuration (48000 samples per second, no carrier).
        // A tick with no table yet must give the high level.
        @(negedge clk);
        send_tick();
        // Fill every slot, so no later walk can touch an entry that was never written. The
        // table mixes both duration extremes, fill segments and all four power codes.
        send_load(0, 100, LVL_LOW);
        send_load(1, MS_PER_SECOND, LVL_OFF);
        send_load(2, 0, 3);
        send_load(3, 1, LVL_OFF);
        send_load(4, 500, LVL_HIGH);
        send_load(5, 0, LVL_LOW);
        send_load(6, 250, LVL_OFF);
        send_load(7, MS_PER_SECOND, 3);
        // A count above the table size saturates.
        send_finish(15);
        send_tick();
        // Second above 59 wraps, and an offset far beyond one second makes every tick a
        // boundary; the walk lands on the fill segment.
        send_start(63, MAX_OFFSET);
        send_tick();
        send_tick();
        // A count of zero means the high level throughout.
        send_finish(0);
        send_tick();
        send_finish(2);
        // One tick before the end of second 59: the next tick rolls the minute over.
        send_start(59, 47999);
        send_tick();
        send_tick();
        // One tick before the end of segment 0; then run past the last valid segment.
        send_start(60, 4799);
        send_tick();
        send_tick();
        send_finish(1);
        send_tick();
        send_tick();
        settle();

        // Random phases, each with its own configuration and idling pattern. Between them
        // the sample rate, carrier switch and phase step are each taken to both extremes.
        program_regs(1000, 1'b1, 32'h0123_4567);
        @(negedge clk);
        random_phase(75);
        settle();

        program_regs(1_000_000, 1'b0, 32'hFFFF_FFFF);
        src_idle_pct = 61;
        @(negedge clk);
        random_phase(75);
        settle();

        program_regs($urandom_range(1000, 5000), 1'b1, 32'hFFFF_FFFF);
        src_idle_pct   = 0;
        sink_stall_pct = 61;
        @(negedge clk);
        random_phase(75);
        settle();

        program_regs(1000, 1'b1, 32'h0);
        src_idle_pct   = 11;
        sink_stall_pct = 11;
        @(negedge clk);
        random_phase(75);
        settle();

        program_regs($urandom_range(1000, 1_000_000), 1'b1, $urandom);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        @(negedge clk);
        random_phase(75);
        settle();

        if (mismatches == 0 && due_samples.size() == 0)
            $display("lf_time_signal_envelope_gen test passed");
        else
            $display("lf_time_signal_envelope_gen test failed");
        $finish;
    end

endmodule
